### rtl/plpt_pkg.sv
// ----------------------------------------------------------------------------
// plpt_pkg
// shared constants and types for the power-law pixel transform
// ----------------------------------------------------------------------------
package plpt_pkg;

  localparam int PIX_W     = 8;
  localparam int LUT_DEPTH = 256;
  localparam int EXP_W     = 3;
  localparam int CFG_W     = 3;
  localparam int ACC_W     = 64;
  localparam int MUL_W     = 9;
  localparam int MAX_POWER = 7;

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

  localparam logic CFG_EXPONENT       = 1'b0;
  localparam logic CFG_RAISE_CONTRAST = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [EXP_W-1:0] exp_t;
  typedef logic [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic   we;
    pixel_t addr;
    pixel_t data;
  } lut_wr_t;

endpackage

### rtl/power_law_pixel_transform.sv
// ----------------------------------------------------------------------------
// power_law_pixel_transform
// gamma transform of 8-bit grey pixels through a 256-entry lookup table
// ----------------------------------------------------------------------------
// After reset and after every configuration write the block rebuilds its
// 256-entry lookup table with a single shared 64x9 multiplier, one multiply
// per cycle in its multiply states; during the rebuild s_axis_tready stays
// low. Once the table is built, one pixel is accepted per clock while the
// output is not stalled; a pixel's result passes through the table ram read
// register and then the output register.
module power_law_pixel_transform (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [2:0] cfg_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // pixel_in
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // pixel_out
);

  plpt_pkg::exp_t    exponent;
  logic              raise_contrast;
  plpt_pkg::exp_t    n_eff;
  plpt_pkg::lut_wr_t lut_wr;
  logic              done;
  logic              rd_valid;
  logic              adv;
  logic              accept;
  plpt_pkg::pixel_t  rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent       <= plpt_pkg::EXP_W'(1);
      raise_contrast <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        plpt_pkg::CFG_EXPONENT:       exponent       <= cfg_data;
        plpt_pkg::CFG_RAISE_CONTRAST: raise_contrast <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign n_eff = (exponent == '0) ? plpt_pkg::EXP_W'(1) : exponent;

  plpt_fill u_fill (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .n_eff   (n_eff),
    .raise   (raise_contrast),
    .lut_wr  (lut_wr),
    .done    (done)
  );

  assign adv    = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = done && (!rd_valid || adv);

  plpt_ram #(
    .WIDTH (plpt_pkg::PIX_W),
    .DEPTH (plpt_pkg::LUT_DEPTH)
  ) u_lut (
    .clk   (clk),
    .we    (lut_wr.we),
    .waddr (lut_wr.addr),
    .wdata (lut_wr.data),
    .re    (accept),
    .raddr (s_axis_tdata),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        rd_valid <= 1'b1;
      end else if (adv) begin
        rd_valid <= 1'b0;
      end
      if (adv) begin
        m_axis_tvalid <= rd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rd_valid) begin
      m_axis_tdata <= rd_data;
    end
  end

endmodule

### rtl/plpt_ram.sv
// ----------------------------------------------------------------------------
// plpt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module plpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/plpt_fill.sv
// ----------------------------------------------------------------------------
// plpt_fill
// table builder: computes every entry of the lookup table with one shared
// multiplier and a bit-wise search, then writes it into the table ram
// ----------------------------------------------------------------------------
module plpt_fill (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  plpt_pkg::exp_t    n_eff,
  input  logic              raise,
  output plpt_pkg::lut_wr_t lut_wr,
  output logic              done
);

  localparam logic [2:0] S_START  = 3'd0;
  localparam logic [2:0] S_DINIT  = 3'd1;
  localparam logic [2:0] S_PSETUP = 3'd2;
  localparam logic [2:0] S_PMUL   = 3'd3;
  localparam logic [2:0] S_BSETUP = 3'd4;
  localparam logic [2:0] S_BMUL   = 3'd5;
  localparam logic [2:0] S_WRITE  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]                   state;
  plpt_pkg::acc_t               acc;
  plpt_pkg::acc_t               d_val;
  plpt_pkg::acc_t               rhs;
  plpt_pkg::exp_t               cnt;
  plpt_pkg::pixel_t             p_idx;
  plpt_pkg::pixel_t             y;
  logic [2:0]                   bitpos;
  plpt_pkg::pixel_t             cand;
  logic [plpt_pkg::MUL_W-1:0]   odd;
  logic [plpt_pkg::MUL_W-1:0]   mul_op;
  logic [plpt_pkg::ACC_W+plpt_pkg::MUL_W-1:0] prod;

  assign cand = y | (plpt_pkg::pixel_t'(1) << bitpos);
  assign odd  = {cand, 1'b0} - plpt_pkg::MUL_W'(1);

  always_comb begin
    unique case (state)
      S_DINIT: mul_op = {1'b0, plpt_pkg::FULL_SCALE};
      S_PMUL:  mul_op = {1'b0, p_idx};
      default: mul_op = odd;
    endcase
  end

  assign prod = acc * mul_op;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= S_START;
    end else begin
      unique case (state)
        S_START: begin
          acc   <= plpt_pkg::ACC_W'(1);
          cnt   <= n_eff - plpt_pkg::EXP_W'(1);
          state <= S_DINIT;
        end
        S_DINIT: begin
          if (cnt == '0) begin
            d_val <= acc;
            p_idx <= '0;
            state <= S_PSETUP;
          end else begin
            acc <= prod[plpt_pkg::ACC_W-1:0];
            cnt <= cnt - plpt_pkg::EXP_W'(1);
          end
        end
        S_PSETUP: begin
          if (raise) begin
            acc <= plpt_pkg::ACC_W'(1);
            cnt <= n_eff;
          end else begin
            acc <= d_val;
            cnt <= plpt_pkg::EXP_W'(1);
          end
          state <= S_PMUL;
        end
        S_PMUL: begin
          if (cnt == '0) begin
            rhs    <= raise ? (acc << 1) : (acc << n_eff);
            y      <= '0;
            bitpos <= 3'd7;
            state  <= S_BSETUP;
          end else begin
            acc <= prod[plpt_pkg::ACC_W-1:0];
            cnt <= cnt - plpt_pkg::EXP_W'(1);
          end
        end
        S_BSETUP: begin
          if (raise) begin
            acc <= d_val;
            cnt <= plpt_pkg::EXP_W'(1);
          end else begin
            acc <= plpt_pkg::ACC_W'(1);
            cnt <= n_eff;
          end
          state <= S_BMUL;
        end
        S_BMUL: begin
          if (cnt == '0) begin
            if (acc <= rhs) begin
              y <= cand;
            end
            if (bitpos == 3'd0) begin
              state <= S_WRITE;
            end else begin
              bitpos <= bitpos - 3'd1;
              state  <= S_BSETUP;
            end
          end else begin
            acc <= prod[plpt_pkg::ACC_W-1:0];
            cnt <= cnt - plpt_pkg::EXP_W'(1);
          end
        end
        S_WRITE: begin
          if (p_idx == plpt_pkg::pixel_t'(plpt_pkg::LUT_DEPTH - 1)) begin
            state <= S_DONE;
          end else begin
            p_idx <= p_idx + plpt_pkg::pixel_t'(1);
            state <= S_PSETUP;
          end
        end
        S_DONE: state <= S_DONE;
        default: state <= S_START;
      endcase
    end
  end

  assign lut_wr.we   = (state == S_WRITE);
  assign lut_wr.addr = p_idx;
  assign lut_wr.data = y;
  assign done        = (state == S_DONE);

endmodule

### rtl/plpt_checker.sv
// ----------------------------------------------------------------------------
// plpt_checker
// port-level checks for the power-law pixel transform
// ----------------------------------------------------------------------------
module plpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready or valid right after reset");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_axis_tready)
    else $error("ready right after a table rebuild started");

endmodule

bind power_law_pixel_transform plpt_checker u_plpt_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_we        (cfg_we),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
